[hdl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the three-set fuzzy classifier.
// ----------------------------------------------------------------------------
package fts_pkg;

    // default widths of the sample and of the degree fraction
    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int DEGREE_FRAC_BITS_DEF = 15;

    // packed breakpoint register width and number of fuzzy sets
    localparam int POINTS_W  = 48;
    localparam int NUM_SETS  = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_ONE   = 2'd0,
        REG_SET_TWO   = 2'd1,
        REG_SET_THREE = 2'd2
    } cfg_reg_t;

    // index of a fuzzy set
    typedef logic [1:0] set_idx_t;

    localparam set_idx_t SET_ONE   = 2'd0;
    localparam set_idx_t SET_TWO   = 2'd1;
    localparam set_idx_t SET_THREE = 2'd2;

endpackage

[hdl/fts_front.sv]
// ----------------------------------------------------------------------------
// fts_front
// Breakpoint registers and ramp setup: turns a sample into a dividend and
// a divisor for each set.
// ----------------------------------------------------------------------------
module fts_front #(
    parameter int SAMPLE_BITS = fts_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fts_pkg::POINTS_W-1:0]        cfg_data,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic [SAMPLE_BITS:0]                rem_init [fts_pkg::NUM_SETS],
    output logic [SAMPLE_BITS-1:0]              span_init [fts_pkg::NUM_SETS]
);
    import fts_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = (3 * SB > POINTS_W) ? 3 * SB : POINTS_W;

    logic [POINTS_W-1:0] points_reg  [NUM_SETS];
    logic [POINTS_W-1:0] points_next [NUM_SETS];

    // register writes, index beyond the last set is dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            points_next[s] = points_reg[s];
        end
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SET_ONE:   points_next[0] = cfg_data;
                REG_SET_TWO:   points_next[1] = cfg_data;
                REG_SET_THREE: points_next[2] = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                points_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                points_reg[s] <= points_next[s];
            end
        end
    end

    // per set: full and empty regions map to 1/1 and 0/1, ramps to offset/span
    always_comb
    begin
        logic [PW-1:0] padded;
        logic [SB-1:0] pa;
        logic [SB-1:0] pb;
        logic [SB-1:0] pc;
        logic          full;
        logic          empty;
        logic          rising;
        logic [SB-1:0] offset;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            padded = PW'(points_reg[s]);
            pa     = padded[SB-1:0];
            pb     = padded[2*SB-1:SB];
            pc     = padded[3*SB-1:2*SB];
            full   = ((pa == pb) && (sample <= pa)) || ((pb == pc) && (sample >= pc));
            empty  = (sample <= pa) || (pc <= sample);
            rising = (sample <= pb);
            if (full)
            begin
                offset       = SB'(1);
                span_init[s] = SB'(1);
            end
            else if (empty)
            begin
                offset       = '0;
                span_init[s] = SB'(1);
            end
            else if (rising)
            begin
                offset       = sample - pa;
                span_init[s] = pb - pa;
            end
            else
            begin
                offset       = pc - sample;
                span_init[s] = pc - pb;
            end
            rem_init[s] = {1'b0, offset};
        end
    end

endmodule

[hdl/fts_div_cell.sv]
// ----------------------------------------------------------------------------
// fts_div_cell
// One restoring division step for all three sets: resolves one quotient bit
// and passes the shifted remainder to the next cell.
// ----------------------------------------------------------------------------
module fts_div_cell #(
    parameter int SAMPLE_BITS = fts_pkg::SAMPLE_BITS_DEF,
    parameter int QUOT_BITS   = fts_pkg::DEGREE_FRAC_BITS_DEF + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_BITS:0]       rem_in   [fts_pkg::NUM_SETS],
    input  logic [SAMPLE_BITS-1:0]     span_in  [fts_pkg::NUM_SETS],
    input  logic [QUOT_BITS-1:0]       quot_in  [fts_pkg::NUM_SETS],
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_BITS:0]       rem_out  [fts_pkg::NUM_SETS],
    output logic [SAMPLE_BITS-1:0]     span_out [fts_pkg::NUM_SETS],
    output logic [QUOT_BITS-1:0]       quot_out [fts_pkg::NUM_SETS]
);
    import fts_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic                 valid_reg;
    logic [SB:0]          rem_reg   [NUM_SETS];
    logic [SB:0]          rem_next  [NUM_SETS];
    logic [SB-1:0]        span_reg  [NUM_SETS];
    logic [QUOT_BITS-1:0] quot_reg  [NUM_SETS];
    logic [QUOT_BITS-1:0] quot_next [NUM_SETS];

    // a bubble or a draining word lets the next word in
    assign in_ready = !valid_reg || out_ready;

    // compare, subtract, shift
    always_comb
    begin
        logic          ge;
        logic [SB:0]   diff;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            ge           = (rem_in[s] >= {1'b0, span_in[s]});
            diff         = ge ? (rem_in[s] - {1'b0, span_in[s]}) : rem_in[s];
            rem_next[s]  = {diff[SB-1:0], 1'b0};
            quot_next[s] = {quot_in[s][QUOT_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                span_reg[s] <= span_in[s];
                quot_reg[s] <= quot_next[s];
            end
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign span_out  = span_reg;
    assign quot_out  = quot_reg;

endmodule

[hdl/fts_pick.sv]
// ----------------------------------------------------------------------------
// fts_pick
// Strongest-set selection and output register for the result word.
// ----------------------------------------------------------------------------
module fts_pick #(
    parameter int QUOT_BITS = fts_pkg::DEGREE_FRAC_BITS_DEF + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [QUOT_BITS-1:0]       quot_in [fts_pkg::NUM_SETS],
    output logic                       out_valid,
    input  logic                       out_ready,
    output fts_pkg::set_idx_t          best_set,
    output logic [QUOT_BITS-1:0]       degree_one,
    output logic [QUOT_BITS-1:0]       degree_two,
    output logic [QUOT_BITS-1:0]       degree_three
);
    import fts_pkg::*;

    localparam logic [QUOT_BITS-1:0] DEGREE_ONE = QUOT_BITS'(1) << (QUOT_BITS - 1);

    logic                 valid_reg;
    set_idx_t             best_reg;
    set_idx_t             best_next;
    logic [QUOT_BITS-1:0] deg_reg [NUM_SETS];

    assign in_ready = !valid_reg || out_ready;

    // argmax, ties keep the lower index
    always_comb
    begin
        logic [QUOT_BITS-1:0] top;
        top       = quot_in[0];
        best_next = SET_ONE;
        if (quot_in[1] > top)
        begin
            top       = quot_in[1];
            best_next = SET_TWO;
        end
        if (quot_in[2] > top)
        begin
            best_next = SET_THREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            best_reg <= best_next;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                deg_reg[s] <= quot_in[s];
            end
        end
    end

    assign out_valid    = valid_reg;
    assign best_set     = best_reg;
    assign degree_one   = deg_reg[0];
    assign degree_two   = deg_reg[1];
    assign degree_three = deg_reg[2];

    // degrees never exceed one
    a_degree_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (deg_reg[0] <= DEGREE_ONE) && (deg_reg[1] <= DEGREE_ONE)
                      && (deg_reg[2] <= DEGREE_ONE))
        else $error("degree above one");

    // the chosen set holds the largest degree
    a_best_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (best_reg != 2'd3)
            && ((best_reg != SET_ONE) || ((deg_reg[0] >= deg_reg[1])
                                          && (deg_reg[0] >= deg_reg[2])))
            && ((best_reg != SET_TWO) || ((deg_reg[1] > deg_reg[0])
                                          && (deg_reg[1] >= deg_reg[2])))
            && ((best_reg != SET_THREE) || ((deg_reg[2] > deg_reg[0])
                                            && (deg_reg[2] > deg_reg[1]))))
        else $error("best set is not the strongest");

    // a stalled result word is not overwritten
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> valid_reg && $stable(best_reg)
                                      && $stable(deg_reg[0]) && $stable(deg_reg[1])
                                      && $stable(deg_reg[2]))
        else $error("result word lost while stalled");

endmodule

[hdl/fuzzy_three_set_classifier.sv]
// ----------------------------------------------------------------------------
// fuzzy_three_set_classifier
// Triangular and shoulder membership of one sample in three fuzzy sets,
// with the index of the strongest set.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while no stall holds in_ready low and
// returns, per sample, the three membership degrees in Q1.DEGREE_FRAC_BITS and
// the index of the strongest set (ties to the lower index). The division of
// ramp offset by span runs through a chain of DEGREE_FRAC_BITS + 1 division
// cells, each resolving one quotient bit for all three sets, then one output
// register holds the result word. Each stage carries its own valid bit, so
// empty stages keep taking words while a result waits on the output.
// Breakpoint registers are written through the configuration port, which is
// always ready; write only while no word is in flight.
module fuzzy_three_set_classifier #(
    parameter int SAMPLE_BITS      = fts_pkg::SAMPLE_BITS_DEF,
    parameter int DEGREE_FRAC_BITS = fts_pkg::DEGREE_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fts_pkg::POINTS_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fts_pkg::set_idx_t                 best_set,
    output logic [DEGREE_FRAC_BITS:0]         degree_one,
    output logic [DEGREE_FRAC_BITS:0]         degree_two,
    output logic [DEGREE_FRAC_BITS:0]         degree_three
);
    import fts_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int QW = DEGREE_FRAC_BITS + 1;

    logic          stage_valid [QW+1];
    logic          stage_ready [QW+1];
    logic [SB:0]   stage_rem   [QW+1][NUM_SETS];
    logic [SB-1:0] stage_span  [QW+1][NUM_SETS];
    logic [QW-1:0] stage_quot  [QW+1][NUM_SETS];

    // breakpoints and ramp setup
    fts_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .rem_init  (stage_rem[0]),
        .span_init (stage_span[0])
    );

    assign stage_valid[0] = in_valid;
    assign in_ready       = stage_ready[0];

    always_comb
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            stage_quot[0][s] = '0;
        end
    end

    // division chain, one quotient bit per cell
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        fts_div_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .QUOT_BITS   (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .rem_in    (stage_rem[i]),
            .span_in   (stage_span[i]),
            .quot_in   (stage_quot[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .rem_out   (stage_rem[i+1]),
            .span_out  (stage_span[i+1]),
            .quot_out  (stage_quot[i+1])
        );
    end

    // strongest set and result word
    fts_pick #(
        .QUOT_BITS (QW)
    ) u_pick (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stage_valid[QW]),
        .in_ready     (stage_ready[QW]),
        .quot_in      (stage_quot[QW]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .best_set     (best_set),
        .degree_one   (degree_one),
        .degree_two   (degree_two),
        .degree_three (degree_three)
    );

endmodule
